// ----- design/s2a_pkg.sv -----
// Package for the sample-to-ASCII frame block: frame byte codes, digit
// extraction types and the decimal digit step function.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package s2a_pkg;

   localparam int FRAME_LEN = 8;
   localparam int DIGIT_W   = 14;   // holds every in-range scaled value

   localparam logic [7:0] STX_BYTE  = 8'h02;
   localparam logic [7:0] DOT_BYTE  = 8'h2E;
   localparam logic [7:0] CR_BYTE   = 8'h0D;
   localparam logic [7:0] ETX_BYTE  = 8'h03;
   localparam logic [7:0] STAR_BYTE = 8'h2A;
   localparam logic [7:0] ZERO_CHAR = 8'h30;

   localparam logic [DIGIT_W-1:0] SCALED_MAX = 14'd9999;
   localparam logic [DIGIT_W-1:0] UNIT_THOU  = 14'd1000;
   localparam logic [DIGIT_W-1:0] UNIT_HUND  = 14'd100;
   localparam logic [DIGIT_W-1:0] UNIT_TEN   = 14'd10;

   typedef logic [FRAME_LEN-1:0][7:0] frame_type;

   typedef struct packed {
      logic [3:0]         digit;
      logic [DIGIT_W-1:0] rem;
   } digit_step_type;

   // One decimal digit: nine parallel compares against multiples of unit,
   // highest hit wins. Callers pass constant units and v < 10 * unit.
   function automatic digit_step_type digit_step(input logic [DIGIT_W-1:0] v,
                                                 input logic [DIGIT_W-1:0] unit);
      digit_step_type r;
      logic [DIGIT_W-1:0] mult;
      r.digit = 4'd0;
      r.rem   = v;
      for (int k = 1; k <= 9; k++) begin
         mult = DIGIT_W'(unit * DIGIT_W'(k));
         if (v >= mult) begin
            r.digit = 4'(k);
            r.rem   = v - mult;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/s2a_req_if.sv -----
// Request channel interface: valid/ready handshake carrying one sample word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface s2a_req_if #(
   parameter int SAMPLE_BITS = 10
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- design/s2a_rsp_if.sv -----
// Response channel interface: valid/ready handshake carrying one frame byte
// and its last-byte flag. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface s2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- design/s2a_convert.sv -----
// Combinational scale-by-7/4 and decimal conversion into an 8-byte frame.
// Depends on s2a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s2a_convert
   import s2a_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic [SAMPLE_BITS-1:0] sample,
   output frame_type                   frame
);

   localparam int PROD_W = SAMPLE_BITS + 3;
   localparam int VAL_W  = SAMPLE_BITS + 1;
   localparam int CMP_W  = (VAL_W > DIGIT_W) ? VAL_W : DIGIT_W;

   logic [PROD_W-1:0]  prod;
   logic [VAL_W-1:0]   val;
   logic [CMP_W-1:0]   val_ext;
   logic               ovf;
   logic [DIGIT_W-1:0] v;
   digit_step_type     thou, hund, tens;

   // 7 * sample as 8x - x, then truncate two bits
   assign prod    = {sample, 3'b000} - {3'b000, sample};
   assign val     = prod[PROD_W-1:2];
   assign val_ext = CMP_W'(val);
   assign ovf     = val_ext > CMP_W'(SCALED_MAX);
   assign v       = val_ext[DIGIT_W-1:0];

   assign thou = digit_step(v, UNIT_THOU);
   assign hund = digit_step(thou.rem, UNIT_HUND);
   assign tens = digit_step(hund.rem, UNIT_TEN);

   always_comb begin
      frame[0] = STX_BYTE;
      frame[2] = DOT_BYTE;
      frame[6] = CR_BYTE;
      frame[7] = ETX_BYTE;
      if (ovf) begin
         frame[1] = STAR_BYTE;
         frame[3] = STAR_BYTE;
         frame[4] = STAR_BYTE;
         frame[5] = STAR_BYTE;
      end else begin
         frame[1] = ZERO_CHAR + {4'h0, thou.digit};
         frame[3] = ZERO_CHAR + {4'h0, hund.digit};
         frame[4] = ZERO_CHAR + {4'h0, tens.digit};
         frame[5] = ZERO_CHAR + {4'h0, tens.rem[3:0]};
      end
   end

endmodule

`default_nettype wire

// ----- design/s2a_serializer.sv -----
// Frame register and byte serializer: holds one 8-byte frame and shifts it
// out a word per handshake. Depends on s2a_pkg and s2a_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module s2a_serializer
   import s2a_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire frame_type frame,
   output logic           free,
   s2a_rsp_if.source      rsp_chan
);

   localparam int CNT_W = $clog2(FRAME_LEN + 1);

   frame_type        frame_ff, frame_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             take;

   assign take = rsp_chan.valid && rsp_chan.ready;
   // free when empty or when the final byte leaves this cycle
   assign free = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && take);

   always_comb begin
      frame_in = frame_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         frame_in = frame;
         cnt_in   = CNT_W'(FRAME_LEN);
      end else if (take) begin
         frame_in = {8'h00, frame_ff[FRAME_LEN-1:1]};
         cnt_in   = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp_chan.valid     = cnt_ff != '0;
   assign rsp_chan.out_byte  = frame_ff[0];
   assign rsp_chan.last_byte = cnt_ff == CNT_W'(1);

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && take))
      else $error("frame loaded over undelivered bytes");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> cnt_ff == CNT_W'(FRAME_LEN))
      else $error("frame count not full after load");

   a_first_stx: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.out_byte == STX_BYTE)
      else $error("frame does not open with STX");

   a_last_etx: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_byte) |-> rsp_chan.out_byte == ETX_BYTE)
      else $error("last byte is not ETX");

endmodule

`default_nettype wire

// ----- design/sample_to_ascii_frame.sv -----
// A sample accepted on the request channel is held in the input register; the
// converted frame loads into the serializer once it is free, and its first
// word (STX) is valid from then on. Sample throughput is set by the eight-word
// frame drain through one port; the next sample waits in the input register
// while a frame drains.
// Reset (synchronous, active high) empties the input register and serializer.
`timescale 1ns / 1ps
`default_nettype none

module sample_to_ascii_frame
   import s2a_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input wire logic   clock,
   input wire logic   reset,
   s2a_req_if.sink    req_chan,
   s2a_rsp_if.source  rsp_chan
);

   // Input register: one sample word and its valid flag.
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic                   smp_vld_ff, smp_vld_in;

   logic      req_take;
   logic      ser_free;
   logic      load;
   frame_type frame;

   // Hand the held sample to the serializer as soon as it has room.
   assign load     = smp_vld_ff && ser_free;
   // Accept while empty, or while the held sample moves on this cycle.
   assign req_chan.ready = !smp_vld_ff || ser_free;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      smp_in     = smp_ff;
      smp_vld_in = smp_vld_ff;
      if (req_take) begin
         // capture the new word; any held word advances at the same edge
         smp_in     = req_chan.sample;
         smp_vld_in = 1'b1;
      end else if (load) begin
         // drop the flag once the word moves into the frame register
         smp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff <= 1'b0;
      end else begin
         smp_vld_ff <= smp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
   end

   // Scale, split into decimal digits and lay out the frame.
   s2a_convert #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_convert (
      .sample (smp_ff),
      .frame  (frame)
   );

   // Hold the frame and advance one word per response handshake.
   s2a_serializer u_serializer (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .frame    (frame),
      .free     (ser_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
